@@ rtl/countdown_event_table_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Countdown event table assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_EVENT_TABLE_UNIT_ASSERT_SVH
`define COUNTDOWN_EVENT_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTH
// property must hold outside reset
`define CET_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cet assertion failed");
// property must hold at every edge, reset included
`define CET_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cet assertion failed");
`else
`define CET_ASSERT(lbl, clk, rst, prop)
`define CET_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/cet_pkg.sv @@
// ----------------------------------------------------------------------------
// Countdown event table package
// Sizes, codes and request/response types shared by the table unit.
// ----------------------------------------------------------------------------
package cet_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int DELAY_BITS  = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int REM_BITS    = DELAY_BITS + 1;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [2:0] KIND_FIRED       = 3'd0;
   localparam logic [2:0] KIND_TICK_DONE   = 3'd1;
   localparam logic [2:0] KIND_INSERT_OK   = 3'd2;
   localparam logic [2:0] KIND_INSERT_FULL = 3'd3;
   localparam logic [2:0] KIND_CANCEL_DONE = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] delay;
      logic [7:0]  handler_id;
      logic [31:0] causer_word;
      logic [31:0] victim_word;
      logic [31:0] info_word;
      logic [31:0] match_key;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  fired_handler;
      logic [31:0] fired_causer;
      logic [31:0] fired_victim;
      logic [31:0] fired_info;
      logic [5:0]  match_count;
      logic        last;
   } rsp_type;

   // front queue head toward the table engine
   typedef struct packed {
      logic    valid;
      req_type req;
   } cmd_link_type;

   // table engine toward the response queue
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } rsp_link_type;

endpackage

@@ rtl/cet_front.sv @@
// ----------------------------------------------------------------------------
// Countdown event table front end
// Accepts requests, drops unused opcodes and queues commands (2 deep).
// ----------------------------------------------------------------------------
module cet_front import cet_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_type      req_data,
   output cmd_link_type cmd_head,
   input  logic         cmd_pop
);

   req_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr;
   logic       do_rd;

   assign full = (cnt_ff == 2'd2);

   always_comb begin
      unique case (req_data.op)
         OP_TICK, OP_INSERT, OP_CANCEL: do_wr = push && !full;
         default:                       do_wr = 1'b0;
      endcase
   end

   assign do_rd = cmd_pop && (cnt_ff != 2'd0);

   assign cmd_head.valid = (cnt_ff != 2'd0);
   assign cmd_head.req   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

@@ rtl/cet_table.sv @@
// ----------------------------------------------------------------------------
// Countdown event table engine
// Holds the entries and runs tick, insert and cancel commands.
// ----------------------------------------------------------------------------
module cet_table import cet_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_link_type cmd_head,
   output logic         cmd_pop,
   output rsp_link_type rsp_wr,
   input  logic         rsp_full
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DEC   = 3'd1;
   localparam logic [2:0] ST_VISIT = 3'd2;
   localparam logic [2:0] ST_TDONE = 3'd3;
   localparam logic [2:0] ST_INS   = 3'd4;
   localparam logic [2:0] ST_CAN   = 3'd5;
   localparam logic [2:0] ST_CNT   = 3'd6;

   logic [2:0]          state_ff, state_in;
   req_type             cmd_ff, cmd_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [REM_BITS-1:0] rem_ff [TABLE_DEPTH];
   logic [REM_BITS-1:0] rem_in [TABLE_DEPTH];
   logic [IDX_BITS-1:0] age_ff [TABLE_DEPTH];
   logic [IDX_BITS-1:0] age_in [TABLE_DEPTH];
   logic [7:0]          handler_ff [TABLE_DEPTH];
   logic [31:0]         causer_ff  [TABLE_DEPTH];
   logic [31:0]         victim_ff  [TABLE_DEPTH];
   logic [31:0]         info_ff    [TABLE_DEPTH];
   logic [CNT_BITS-1:0] occ_ff, occ_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] rank_ff, rank_in;
   logic [CNT_BITS-1:0] rmv_ff, rmv_in;
   logic [TABLE_DEPTH-1:0] match_ff, match_in;

   logic [TABLE_DEPTH-1:0] hit;
   logic [REM_BITS-1:0] sel_rem;
   logic [7:0]          sel_handler;
   logic [31:0]         sel_causer;
   logic [31:0]         sel_victim;
   logic [31:0]         sel_info;
   logic [IDX_BITS-1:0] free_idx;
   logic                ins_we;
   logic [CNT_BITS-1:0] match_cnt;
   logic [CNT_BITS-1:0] keep_rank;
   logic                gone;

   // entry visited this cycle: the one whose rank equals the visit counter
   always_comb begin
      sel_rem     = '0;
      sel_handler = '0;
      sel_causer  = '0;
      sel_victim  = '0;
      sel_info    = '0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         hit[s] = valid_ff[s] && (age_ff[s] == rank_ff[IDX_BITS-1:0]);
         if (hit[s]) begin
            sel_rem     = sel_rem     | rem_ff[s];
            sel_handler = sel_handler | handler_ff[s];
            sel_causer  = sel_causer  | causer_ff[s];
            sel_victim  = sel_victim  | victim_ff[s];
            sel_info    = sel_info    | info_ff[s];
         end
      end
   end

   // reaching zero fires, reaching minus one drops
   assign gone      = (sel_rem == '0) || (sel_rem == '1);
   assign keep_rank = rank_ff - rmv_ff;

   always_comb begin
      free_idx = '0;
      for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
         if (!valid_ff[s]) free_idx = IDX_BITS'(s);
      end
   end

   always_comb begin
      match_cnt = '0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         match_cnt = match_cnt + CNT_BITS'(match_ff[s]);
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      valid_in = valid_ff;
      occ_in   = occ_ff;
      cnt_in   = cnt_ff;
      rank_in  = rank_ff;
      rmv_in   = rmv_ff;
      match_in = match_ff;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         rem_in[s] = rem_ff[s];
         age_in[s] = age_ff[s];
      end
      cmd_pop    = 1'b0;
      ins_we     = 1'b0;
      rsp_wr     = '0;
      rsp_wr.rsp.last = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_head.valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head.req;
               unique case (cmd_head.req.op)
                  OP_TICK:   state_in = ST_DEC;
                  OP_INSERT: state_in = ST_INS;
                  default:   state_in = ST_CAN;
               endcase
            end
         end
         ST_DEC: begin
            for (int s = 0; s < TABLE_DEPTH; s++) begin
               if (valid_ff[s]) rem_in[s] = rem_ff[s] - 1'b1;
            end
            cnt_in   = occ_ff;
            rank_in  = '0;
            rmv_in   = '0;
            state_in = ST_VISIT;
         end
         ST_VISIT: begin
            if (rank_ff == cnt_ff) begin
               state_in = ST_TDONE;
            end else if (!rsp_full) begin
               rank_in = rank_ff + 1'b1;
               if (gone) begin
                  valid_in = valid_ff & ~hit;
                  rmv_in   = rmv_ff + 1'b1;
                  occ_in   = occ_ff - 1'b1;
                  if (sel_rem == '0 && sel_handler != 8'd0) begin
                     rsp_wr.valid             = 1'b1;
                     rsp_wr.rsp.kind          = KIND_FIRED;
                     rsp_wr.rsp.fired_handler = sel_handler;
                     rsp_wr.rsp.fired_causer  = sel_causer;
                     rsp_wr.rsp.fired_victim  = sel_victim;
                     rsp_wr.rsp.fired_info    = sel_info;
                     rsp_wr.rsp.last          = 1'b0;
                  end
               end else begin
                  // survivors close the gaps left by removed entries
                  for (int s = 0; s < TABLE_DEPTH; s++) begin
                     if (hit[s]) age_in[s] = keep_rank[IDX_BITS-1:0];
                  end
               end
            end
         end
         ST_TDONE: begin
            if (!rsp_full) begin
               rsp_wr.valid    = 1'b1;
               rsp_wr.rsp.kind = KIND_TICK_DONE;
               state_in        = ST_IDLE;
            end
         end
         ST_INS: begin
            if (!rsp_full) begin
               rsp_wr.valid = 1'b1;
               state_in     = ST_IDLE;
               if (occ_ff == CNT_BITS'(TABLE_DEPTH)) begin
                  rsp_wr.rsp.kind = KIND_INSERT_FULL;
               end else begin
                  rsp_wr.rsp.kind = KIND_INSERT_OK;
                  ins_we          = 1'b1;
                  occ_in          = occ_ff + 1'b1;
                  for (int s = 0; s < TABLE_DEPTH; s++) begin
                     if (valid_ff[s]) age_in[s] = age_ff[s] + 1'b1;
                  end
                  valid_in[free_idx] = 1'b1;
                  age_in[free_idx]   = '0;
                  rem_in[free_idx]   = REM_BITS'(cmd_ff.delay[DELAY_BITS-1:0]);
               end
            end
         end
         ST_CAN: begin
            for (int s = 0; s < TABLE_DEPTH; s++) begin
               match_in[s] = valid_ff[s] &&
                  (causer_ff[s] == cmd_ff.match_key ||
                   victim_ff[s] == cmd_ff.match_key ||
                   {24'd0, handler_ff[s]} == cmd_ff.match_key);
               if (match_in[s]) rem_in[s] = '0;
            end
            state_in = ST_CNT;
         end
         ST_CNT: begin
            if (!rsp_full) begin
               rsp_wr.valid           = 1'b1;
               rsp_wr.rsp.kind        = KIND_CANCEL_DONE;
               rsp_wr.rsp.match_count = 6'(match_cnt);
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      cnt_ff   <= cnt_in;
      rank_ff  <= rank_in;
      rmv_ff   <= rmv_in;
      match_ff <= match_in;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         rem_ff[s] <= rem_in[s];
         age_ff[s] <= age_in[s];
      end
      if (ins_we) begin
         handler_ff[free_idx] <= cmd_ff.handler_id;
         causer_ff[free_idx]  <= cmd_ff.causer_word;
         victim_ff[free_idx]  <= cmd_ff.victim_word;
         info_ff[free_idx]    <= cmd_ff.info_word;
      end
   end

endmodule

@@ rtl/cet_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// Countdown event table response queue
// Two-entry queue between the table engine and the response port.
// ----------------------------------------------------------------------------
module cet_rsp_queue import cet_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_link_type rsp_wr,
   output logic         rsp_full,
   output logic         empty,
   input  logic         pop,
   output rsp_type      rsp_data
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr;
   logic       do_rd;

   assign rsp_full = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_wr    = rsp_wr.valid && !rsp_full;
   assign do_rd    = pop && !empty;
   assign rsp_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= rsp_wr.rsp;
      end
   end

endmodule

@@ rtl/countdown_event_table_unit.sv @@
// ----------------------------------------------------------------------------
// Countdown event table unit
// Table of 32 pending timed events with tick, insert and cancel requests.
// ----------------------------------------------------------------------------
// Requests enter through push/full; a request is taken when push is high and
// full is low. Op 0 ticks, op 1 inserts an event, op 2 cancels by key; op 3
// is taken and discarded. Responses leave through empty/pop; rsp_data holds
// the oldest response while empty is low, and last marks the final response
// of a request.
// Insert: ST_INS in the engine, one response. Cancel: ST_CAN then ST_CNT, one
// response with the match count. Tick: ST_DEC, then ST_VISIT over the stored
// entries, one per cycle newest first while the response queue has room, one
// response per event reaching zero with a nonzero handler, then ST_TDONE for
// a closing tick-done response. The engine runs one request at a time; a
// two-deep request queue in front and a two-deep response queue behind let
// either side stall alone. When pop stays low the engine halts on the next
// response until there is room. Reset empties the table and both queues.
// ----------------------------------------------------------------------------
module countdown_event_table_unit import cet_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

`include "countdown_event_table_unit_assert.svh"

   cmd_link_type cmd_head;
   logic         cmd_pop;
   rsp_link_type rsp_wr;
   logic         rsp_full;

   cet_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop)
   );

   cet_table u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop),
      .rsp_wr   (rsp_wr),
      .rsp_full (rsp_full)
   );

   cet_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_wr   (rsp_wr),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   `CET_ASSERT(a_no_rsp_overflow, clock, reset, !(rsp_wr.valid && rsp_full))
   `CET_ASSERT(a_pop_needs_cmd, clock, reset, cmd_pop |-> cmd_head.valid)
   `CET_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (empty && !full))

endmodule
